>>> rtl/maglev_table_build_and_lookup_top_assert.svh
// Assertion macros used by the Maglev table engine datapath.
`ifndef MAGLEV_TABLE_BUILD_AND_LOOKUP_TOP_ASSERT_SVH
`define MAGLEV_TABLE_BUILD_AND_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MLV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MLV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mlv_pkg.sv
// Package: request/response types, mode codes and default sizes.
`default_nettype none
package mlv_pkg;

    localparam int RING_LEN_DEF  = 251;
    localparam int MAX_NODES_DEF = 16;
    localparam int POS_W         = 16;
    localparam int HASH_W        = 32;
    localparam int HASH_BYTES    = HASH_W / 8;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_BUILD  = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [3:0]        node_slot;
        logic [POS_W-1:0]  node_position;
        logic [7:0]        perm_offset;
        logic [7:0]        perm_skip;
        logic [4:0]        up_count;
        logic [HASH_W-1:0] hash_key;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] backend_position;
        logic             done_res;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic probe;
        logic mod_step;
        logic rd_issue;
        logic respond;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] in_mode;
        logic       n_zero;
        logic       build_stop;
        logic       mod_last;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

>>> rtl/mlv_req_if.sv
// Request channel interface.
`default_nettype none
interface mlv_req_if;
    logic          valid;
    logic          ready;
    mlv_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mlv_rsp_if.sv
// Response channel interface.
`default_nettype none
interface mlv_rsp_if;
    logic          valid;
    logic          ready;
    mlv_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mlv_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module mlv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 251
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/mlv_ctl.sv
// Controller: sequences load, build, lookup and response.
`default_nettype none
module mlv_ctl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire mlv_pkg::status_t st,
    output mlv_pkg::cmd_t        cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BUILD = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.in_mode == mlv_pkg::MODE_BUILD)
                    begin
                        state_next = st.n_zero ? S_RESP : S_BUILD;
                    end
                    else if (st.in_mode == mlv_pkg::MODE_LOOKUP)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_BUILD:
            begin
                cmd.probe = 1'b1;
                if (st.build_stop)
                begin
                    state_next = S_RESP;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (st.mod_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                cmd.respond = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/mlv_dp.sv
// Datapath: backend registers, ring walk, slot table, hash reduction, output register.
`default_nettype none
`include "maglev_table_build_and_lookup_top_assert.svh"
module mlv_dp #(
    parameter int RING_LEN  = mlv_pkg::RING_LEN_DEF,
    parameter int MAX_NODES = mlv_pkg::MAX_NODES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mlv_pkg::req_t req_data,
    input  wire mlv_pkg::cmd_t cmd,
    output mlv_pkg::status_t   st,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mlv_pkg::rsp_t      rsp_data
);
    localparam int RING_W  = $clog2(RING_LEN);
    localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ARITH_W = ((RING_W > 8) ? RING_W : 8) + 1;
    localparam int FILL_W  = $clog2(RING_LEN + 1);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W   = (NCNT_W > 5) ? NCNT_W : 5;
    localparam int BCNT_W  = $clog2(mlv_pkg::HASH_BYTES);

    // One byte of long division by the ring size, one bit per step
    function automatic logic [ARITH_W-1:0] red8(input logic [ARITH_W-1:0] r_in,
                                                input logic [7:0] b);
        logic [ARITH_W-1:0] r;
        r = r_in;
        for (int k = 7; k >= 0; k--)
        begin
            r = {r[ARITH_W-2:0], b[k]};
            if (r >= ARITH_W'(RING_LEN))
            begin
                r = r - ARITH_W'(RING_LEN);
            end
        end
        return r;
    endfunction

    // Backend registers (offset and skip kept reduced)
    logic [RING_W-1:0]        off_reg  [MAX_NODES];
    logic [RING_W-1:0]        skip_reg [MAX_NODES];
    logic [mlv_pkg::POS_W-1:0] pos_reg [MAX_NODES];
    logic [RING_W-1:0]        cur_reg  [MAX_NODES];

    // Build walk state
    logic [RING_LEN-1:0]  valid_reg;
    logic [NODE_W-1:0]    rank_reg;
    logic [NODE_W-1:0]    last_rank_reg;
    logic [RING_W-1:0]    probes_reg;
    logic [FILL_W-1:0]    filled_reg;
    logic                 claimed_reg;

    // Lookup state and item info
    logic [mlv_pkg::HASH_W-1:0] hash_reg;
    logic [RING_W-1:0]          rem_reg;
    logic [BCNT_W-1:0]          bcnt_reg;
    logic                       hitq_reg;
    logic [1:0]                 mode_reg;
    logic                       load_ok_reg;

    logic                       rsp_valid_reg;
    mlv_pkg::rsp_t              rsp_reg;
    mlv_pkg::rsp_t              rsp_next;

    logic [mlv_pkg::POS_W-1:0]  ram_rdata;

    // Incoming item decode
    logic [CMP_W-1:0]   n_sat;
    logic               in_load_ok;
    logic [NODE_W-1:0]  in_idx;
    logic [ARITH_W-1:0] in_off_red;
    logic [ARITH_W-1:0] in_skip_red;

    always_comb
    begin
        n_sat = (CMP_W'(req_data.up_count) > CMP_W'(MAX_NODES)) ?
                CMP_W'(MAX_NODES) : CMP_W'(req_data.up_count);
        in_load_ok  = CMP_W'(req_data.node_slot) < CMP_W'(MAX_NODES);
        in_idx      = NODE_W'(req_data.node_slot);
        in_off_red  = red8('0, req_data.perm_offset);
        in_skip_red = red8('0, req_data.perm_skip);
        if (in_skip_red == '0)
        begin
            in_skip_red = ARITH_W'(1);
        end
    end

    // Ring walk for the current rank
    logic [RING_W-1:0]  cur;
    logic [ARITH_W-1:0] adv_sum;
    logic [RING_W-1:0]  adv;
    logic               claim;
    logic               turn_end;
    logic               round_end;
    logic               build_stop;

    always_comb
    begin
        cur     = cur_reg[rank_reg];
        adv_sum = ARITH_W'(cur) + ARITH_W'(skip_reg[rank_reg]);
        if (adv_sum >= ARITH_W'(RING_LEN))
        begin
            adv_sum = adv_sum - ARITH_W'(RING_LEN);
        end
        adv        = RING_W'(adv_sum);
        claim      = !valid_reg[cur];
        turn_end   = claim || (probes_reg == RING_W'(RING_LEN - 1));
        round_end  = turn_end && (rank_reg == last_rank_reg);
        build_stop = (claim && (filled_reg == FILL_W'(RING_LEN - 1)))
                  || (round_end && !(claimed_reg || claim));
    end

    // Hash reduction step
    logic [ARITH_W-1:0] rem_step;
    assign rem_step = red8(ARITH_W'(rem_reg), hash_reg[mlv_pkg::HASH_W-1 -: 8]);

    // Status to controller
    always_comb
    begin
        st.in_mode    = req_data.mode;
        st.n_zero     = (req_data.up_count == '0);
        st.build_stop = build_stop;
        st.mod_last   = (bcnt_reg == BCNT_W'(mlv_pkg::HASH_BYTES - 1));
        st.out_free   = !rsp_valid_reg || rsp_ready;
    end

    // Backend registers and per-rank walk position
    always_ff @(posedge clk)
    begin
        if (cmd.accept && req_data.mode == mlv_pkg::MODE_LOAD && in_load_ok)
        begin
            off_reg[in_idx]  <= RING_W'(in_off_red);
            skip_reg[in_idx] <= RING_W'(in_skip_red);
            pos_reg[in_idx]  <= req_data.node_position;
        end
        if (cmd.accept && req_data.mode == mlv_pkg::MODE_BUILD)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                cur_reg[i] <= off_reg[i];
            end
        end
        else if (cmd.probe)
        begin
            cur_reg[rank_reg] <= adv;
        end
    end

    // Build control and slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rank_reg      <= '0;
            last_rank_reg <= '0;
            probes_reg    <= '0;
            filled_reg    <= '0;
            claimed_reg   <= 1'b0;
        end
        else if (cmd.accept && req_data.mode == mlv_pkg::MODE_BUILD)
        begin
            valid_reg     <= '0;
            rank_reg      <= '0;
            last_rank_reg <= NODE_W'(n_sat - CMP_W'(1));
            probes_reg    <= '0;
            filled_reg    <= '0;
            claimed_reg   <= 1'b0;
        end
        else if (cmd.probe)
        begin
            if (claim)
            begin
                valid_reg[cur] <= 1'b1;
                filled_reg     <= filled_reg + FILL_W'(1);
            end
            if (turn_end)
            begin
                probes_reg <= '0;
                rank_reg   <= round_end ? '0 : rank_reg + NODE_W'(1);
                claimed_reg <= round_end ? 1'b0 : (claimed_reg || claim);
            end
            else
            begin
                probes_reg <= probes_reg + RING_W'(1);
            end
        end
    end

    // Lookup reduction and item bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg    <= req_data.mode;
            load_ok_reg <= in_load_ok;
            hash_reg    <= req_data.hash_key;
            rem_reg     <= '0;
            bcnt_reg    <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg  <= RING_W'(rem_step);
            hash_reg <= {hash_reg[mlv_pkg::HASH_W-9:0], 8'h00};
            bcnt_reg <= bcnt_reg + BCNT_W'(1);
        end
        if (cmd.rd_issue)
        begin
            hitq_reg <= valid_reg[rem_reg];
        end
    end

    mlv_ram #(
        .WIDTH (mlv_pkg::POS_W),
        .DEPTH (RING_LEN)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.probe && claim),
        .waddr (cur),
        .wdata (pos_reg[rank_reg]),
        .re    (cmd.rd_issue),
        .raddr (rem_reg),
        .rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response for the request in hand
    always_comb
    begin
        rsp_next = '0;
        case (mode_reg)
            mlv_pkg::MODE_LOAD:
            begin
                rsp_next.done_res = load_ok_reg;
            end
            mlv_pkg::MODE_BUILD:
            begin
                rsp_next.done_res = 1'b1;
            end
            mlv_pkg::MODE_LOOKUP:
            begin
                rsp_next.hit              = hitq_reg;
                rsp_next.backend_position = hitq_reg ? ram_rdata : '0;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `MLV_ASSERT_IMP(a_fill_bound, 1'b1, filled_reg <= FILL_W'(RING_LEN), "fill count past ring")
    `MLV_ASSERT_NXT(a_claim_sets, cmd.probe && claim && !cmd.accept, valid_reg[$past(cur)], "claimed slot not marked")
    `MLV_ASSERT_IMP(a_rank_bound, cmd.probe, rank_reg <= last_rank_reg, "rank beyond last up backend")
endmodule
`default_nettype wire

>>> rtl/maglev_table_build_and_lookup_top.sv
// Maglev table engine: handles one request at a time, through to its response.
// Lookup reduces the hash one byte per cycle, then one slot RAM read.
// Build walks the ring one probe at a time (at least one probe per slot
// when any backend is up; no probes with zero backends).
// A new request is taken once the previous response is in the output register.
// Reset clears all slot valid bits at once (table empty); no clearing pass.
`default_nettype none
module maglev_table_build_and_lookup_top #(
    parameter int RING_LEN  = mlv_pkg::RING_LEN_DEF,
    parameter int MAX_NODES = mlv_pkg::MAX_NODES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    mlv_req_if.sink  req,
    mlv_rsp_if.source rsp
);
    mlv_pkg::cmd_t    cmd;
    mlv_pkg::status_t st;

    mlv_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    mlv_dp #(
        .RING_LEN  (RING_LEN),
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data)
    );
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the Maglev table build and lookup engine.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING       = mlv_pkg::RING_LEN_DEF;
    localparam int NODES      = mlv_pkg::MAX_NODES_DEF;
    localparam int N_RANDOM   = 1250;
    localparam int IDLE_LIMIT = 200000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        mlv_pkg::req_t r;
        bit            typed;
        mlv_pkg::rsp_t e;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mlv_req_if req_ch ();
    mlv_rsp_if rsp_ch ();

    maglev_table_build_and_lookup_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predictor state
    logic [16:0]  ring_slots [RING];
    logic [7:0]   be_offset  [NODES];
    logic [7:0]   be_skip    [NODES];
    logic [15:0]  be_pos     [NODES];
    int unsigned  be_next    [NODES];
    bit           be_loaded  [NODES];

    mlv_pkg::rsp_t pending_rsp [$];
    stim_row_t     directed [$];

    int errors;
    int idle_cycles;
    int n_loads, n_builds, n_lookups, n_hits, n_rsp;
    int burst_left;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Fill the ring the way the engine does: ranks take turns claiming free slots
    function automatic void fill_ring(input logic [4:0] count);
        int unsigned n, filled, off, sk, cur, probes;
        bit claimed;
        n = (count > NODES) ? NODES : count;
        filled = 0;
        for (int s = 0; s < RING; s++)
            ring_slots[s] = '0;
        for (int i = 0; i < n; i++)
            be_next[i] = 0;
        if (n == 0)
            return;
        while (filled < RING)
        begin
            claimed = 0;
            for (int i = 0; i < n && filled < RING; i++)
            begin
                off = be_offset[i] % RING;
                sk  = be_skip[i] % RING;
                if (sk == 0)
                    sk = 1;
                probes = 0;
                cur = (off + be_next[i] * sk) % RING;
                while (ring_slots[cur][16] && probes < RING)
                begin
                    be_next[i] = (be_next[i] + 1) % RING;
                    cur = (off + be_next[i] * sk) % RING;
                    probes++;
                end
                if (!ring_slots[cur][16])
                begin
                    ring_slots[cur] = {1'b1, be_pos[i]};
                    be_next[i] = (be_next[i] + 1) % RING;
                    filled++;
                    claimed = 1;
                end
            end
            if (!claimed)
                break;
        end
    endfunction

    // Expected response for one request; updates the predictor state
    function automatic mlv_pkg::rsp_t table_response(input mlv_pkg::req_t r);
        mlv_pkg::rsp_t o;
        logic [16:0] e;
        o = '0;
        case (r.mode)
            mlv_pkg::MODE_LOAD:
            begin
                be_pos[r.node_slot]    = r.node_position;
                be_offset[r.node_slot] = r.perm_offset;
                be_skip[r.node_slot]   = r.perm_skip;
                be_loaded[r.node_slot] = 1;
                o.done_res = 1'b1;
            end
            mlv_pkg::MODE_BUILD:
            begin
                fill_ring(r.up_count);
                o.done_res = 1'b1;
            end
            mlv_pkg::MODE_LOOKUP:
            begin
                e = ring_slots[r.hash_key % RING];
                if (e[16])
                begin
                    o.hit = 1'b1;
                    o.backend_position = e[15:0];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic mlv_pkg::req_t mk_req(input logic [1:0] md, input logic [3:0] slot,
                                             input logic [15:0] pos, input logic [7:0] off,
                                             input logic [7:0] sk, input logic [4:0] up,
                                             input logic [31:0] key);
        mlv_pkg::req_t r;
        r.mode = md;
        r.node_slot = slot;
        r.node_position = pos;
        r.perm_offset = off;
        r.perm_skip = sk;
        r.up_count = up;
        r.hash_key = key;
        return r;
    endfunction

    function automatic void add_row(input mlv_pkg::req_t r, input bit typed,
                                    input mlv_pkg::rsp_t e);
        stim_row_t row;
        row.r = r;
        row.typed = typed;
        row.e = e;
        directed.push_back(row);
    endfunction

    // Number of ranks loaded contiguously from rank 0: a build may use only these
    function automatic int loaded_prefix();
        int k;
        k = 0;
        while (k < NODES && be_loaded[k])
            k++;
        return k;
    endfunction

    // Drive one request, with random bursts and gaps, and wait for acceptance
    task automatic send_request(input mlv_pkg::req_t r, input bit typed,
                                input mlv_pkg::rsp_t e);
        mlv_pkg::rsp_t exp_rsp;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                req_ch.valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        exp_rsp = table_response(r);
        pending_rsp.push_back(typed ? e : exp_rsp);
        case (r.mode)
            mlv_pkg::MODE_LOAD:   n_loads++;
            mlv_pkg::MODE_BUILD:  n_builds++;
            mlv_pkg::MODE_LOOKUP: n_lookups++;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Receiver stall pattern: phases of always-ready, coin-flip and mostly-stalled
    int unsigned stall_phase;
    int unsigned stall_count;
    always @(negedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_phase = $urandom_range(0, 2);
            stall_count = $urandom_range(16, 96);
        end
        stall_count--;
        case (stall_phase)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = $urandom_range(0, 1);
            default: rsp_ch.ready = ($urandom_range(0, 4) == 0);
        endcase
    end

    // Response check
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_rsp++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response hit=%0b pos=%0h done=%0b", $time,
                         rsp_ch.data.hit, rsp_ch.data.backend_position,
                         rsp_ch.data.done_res);
                errors++;
            end
            else
            begin
                mlv_pkg::rsp_t x;
                x = pending_rsp.pop_front();
                if (rsp_ch.data.hit !== x.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, x.hit,
                             rsp_ch.data.hit);
                    errors++;
                end
                if (rsp_ch.data.backend_position !== x.backend_position)
                begin
                    $display("%0t: backend_position expected %0h actual %0h", $time,
                             x.backend_position, rsp_ch.data.backend_position);
                    errors++;
                end
                if (rsp_ch.data.done_res !== x.done_res)
                begin
                    $display("%0t: done_res expected %0b actual %0b", $time, x.done_res,
                             rsp_ch.data.done_res);
                    errors++;
                end
                if (x.hit)
                    n_hits++;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("maglev_table_build_and_lookup_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        mlv_pkg::rsp_t z, d;
        mlv_pkg::req_t r;
        int pick, k;
        errors = 0;
        idle_cycles = 0;
        n_loads = 0; n_builds = 0; n_lookups = 0; n_hits = 0; n_rsp = 0;
        burst_left = 0;
        stall_count = 0;
        stall_phase = 0;
        rsp_ch.ready = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rst_n = 1'b0;
        for (int s = 0; s < RING; s++)
            ring_slots[s] = '0;
        for (int i = 0; i < NODES; i++)
        begin
            be_next[i] = 0;
            be_loaded[i] = 0;
            be_offset[i] = '0;
            be_skip[i] = '0;
            be_pos[i] = '0;
        end
        z = '0;
        d = '0;
        d.done_res = 1'b1;

        // Directed requests
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'd0), 1, z);     // empty after reset
        add_row(mk_req(MODE_UNUSED, 4'hf, 16'hffff, 8'hff, 8'hff, 5'h1f, '1), 1, z);
        add_row(mk_req(mlv_pkg::MODE_BUILD, 0, 0, 0, 0, 5'd0, 0), 1, d);       // no backends
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'hffff_ffff), 1, z);
        add_row(mk_req(mlv_pkg::MODE_LOAD, 4'd0, 16'h0000, 8'd0, 8'd1, 0, 0), 1, d);
        add_row(mk_req(mlv_pkg::MODE_BUILD, 0, 0, 0, 0, 5'd1, 0), 1, d);       // single backend
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'd250), 0, z);
        // offset out of range and zero skip, then offset and skip at the range top
        add_row(mk_req(mlv_pkg::MODE_LOAD, 4'd1, 16'hffff, 8'hff, 8'd0, 0, 0), 1, d);
        add_row(mk_req(mlv_pkg::MODE_LOAD, 4'd2, 16'h8001, 8'd250, 8'd250, 0, 0), 1, d);
        // skip reduces to zero
        add_row(mk_req(mlv_pkg::MODE_LOAD, 4'd3, 16'h1234, 8'd251, 8'd251, 0, 0), 1, d);
        add_row(mk_req(mlv_pkg::MODE_BUILD, 0, 0, 0, 0, 5'd4, 0), 1, d);
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'd0), 0, z);
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'd251), 0, z);
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'hffff_ffff), 0, z);
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'h8000_0000), 0, z);
        for (int i = 4; i < NODES; i++)
            add_row(mk_req(mlv_pkg::MODE_LOAD, i[3:0], 16'(i * 16'h1111), 8'(i * 17),
                           8'(i * 13 + 1), 0, 0), 1, d);
        // saturates to all ranks
        add_row(mk_req(mlv_pkg::MODE_BUILD, 0, 0, 0, 0, 5'd31, 0), 1, d);
        add_row(mk_req(mlv_pkg::MODE_LOOKUP, 0, 0, 0, 0, 0, 32'd123), 0, z);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_request(directed[i].r, directed[i].typed, directed[i].e);

        // Random requests
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                wait_drained();
            r.mode          = mlv_pkg::MODE_LOOKUP;
            r.node_slot     = $urandom_range(0, 15);
            r.node_position = $urandom_range(0, 65535);
            r.perm_offset   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 250);
            r.perm_skip     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(1, 250);
            r.hash_key      = $urandom;
            r.up_count      = 0;
            pick = $urandom_range(0, 99);
            if (pick < 25)
                r.mode = mlv_pkg::MODE_LOAD;
            else if (pick < 30)
            begin
                r.mode = mlv_pkg::MODE_BUILD;
                k = loaded_prefix();
                if (k == NODES && $urandom_range(0, 3) == 0)
                    r.up_count = $urandom_range(NODES, 31);
                else
                    r.up_count = $urandom_range(0, k);
            end
            else if (pick < 33)
                r.mode = MODE_UNUSED;
            send_request(r, 0, z);
        end

        wait_drained();
        repeat (50) @(posedge clk);

        $display("Covered %0d loads, %0d builds, %0d lookups (%0d hits); %0d responses checked.",
                 n_loads, n_builds, n_lookups, n_hits, n_rsp);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("maglev_table_build_and_lookup_top regression: pass");
        else
            $display("maglev_table_build_and_lookup_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
